>>> rtl/core/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'd61;

	// register indexes of the configuration port
	localparam logic [1:0] REG_GROUPS_PER_LINE = 2'd0;
	localparam logic [1:0] REG_EOL_LENGTH      = 2'd1;
	localparam logic [1:0] REG_EOL_FIRST       = 2'd2;
	localparam logic [1:0] REG_EOL_SECOND      = 2'd3;

	localparam logic [5:0] RST_GROUPS_PER_LINE = 6'd19;
	localparam logic [1:0] RST_EOL_LENGTH      = 2'd2;
	localparam logic [7:0] RST_EOL_FIRST       = 8'd13;
	localparam logic [7:0] RST_EOL_SECOND      = 8'd10;

	// output slot of a group: two line-break slots, then four characters
	localparam logic [2:0] POS_EOL_FIRST  = 3'd0;
	localparam logic [2:0] POS_EOL_SECOND = 3'd1;
	localparam logic [2:0] POS_CHAR0      = 3'd2;
	localparam logic [2:0] POS_CHAR3      = 3'd5;

	typedef struct packed {
		logic [5:0] groups_per_line;
		logic [1:0] eol_length;
		logic [7:0] eol_first;
		logic [7:0] eol_second;
	} cfg_t;

	typedef struct packed {
		logic [23:0] group;    // bytes left aligned, zero padded
		logic [1:0]  nbytes;   // 1..3
		logic [1:0]  elen;     // line-break bytes ahead of the group, 0..2
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] six);
		logic [7:0] c;
		if (six < 6'd26) begin
			c = 8'd65 + {2'b00, six};
		end else if (six < 6'd52) begin
			c = 8'd71 + {2'b00, six};          // 'a' - 26
		end else if (six < 6'd62) begin
			c = {2'b00, six} - 8'd4;           // '0' + (six - 52)
		end else if (six == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

>>> rtl/core/b64e_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_fifo
// Small job queue between the byte packer and the character emitter.
// ----------------------------------------------------------------------------
module b64e_fifo #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH   // 2 or more
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output b64e_pkg::job_t head_job,
	output logic           not_empty
);
	import b64e_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("queue count out of range");

endmodule

>>> rtl/core/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Gathers bytes into groups, decides line breaks, and queues one job per group.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic           clk,
	input  logic           arst_n,
	input  b64e_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	input  logic           queue_full,
	output logic           push,
	output b64e_pkg::job_t push_job
);
	import b64e_pkg::*;

	logic [15:0] held_q;
	logic [1:0]  held_count_q;
	logic [5:0]  gil_q;

	logic        accept;
	logic        brk;
	logic [5:0]  line_len;
	logic [5:0]  gil_next;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (final_byte || held_count_q == 2'd2);

	assign line_len = (cfg.groups_per_line == 6'd0) ? 6'd1 : cfg.groups_per_line;
	assign brk      = (gil_q >= line_len);
	assign gil_next = brk ? 6'd1 : gil_q + 6'd1;

	always_comb begin
		push_job.nbytes = held_count_q + 2'd1;
		push_job.elen   = 2'd0;
		if (brk) begin
			push_job.elen = (cfg.eol_length == 2'd3) ? 2'd2 : cfg.eol_length;
		end
		case (held_count_q)
			2'd0:    push_job.group = {data_byte, 16'h0000};
			2'd1:    push_job.group = {held_q[7:0], data_byte, 8'h00};
			default: push_job.group = {held_q, data_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_count_q <= '0;
			gil_q        <= '0;
		end else if (accept) begin
			if (push) begin
				held_count_q <= '0;
				gil_q        <= final_byte ? 6'd0 : gil_next;
			end else begin
				held_q       <= {held_q[7:0], data_byte};
				held_count_q <= held_count_q + 2'd1;
			end
		end
	end

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd3)
		else $error("more than two bytes held");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_byte) |=> (held_count_q == 2'd0 && gil_q == 6'd0))
		else $error("message state not cleared after final byte");

	a_final_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_byte) |-> push)
		else $error("final byte did not flush a group");

endmodule

>>> rtl/core/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Pulls group jobs from the queue and emits line-break bytes and characters.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64e_pkg::cfg_t cfg,
	input  logic           queue_not_empty,
	input  b64e_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_char,
	output logic           run_last
);
	import b64e_pkg::*;

	job_t       job_q;
	logic       job_valid_q;
	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;

	logic       load_out;
	logic       job_done;
	logic [1:0] k;
	logic [5:0] six;
	logic [7:0] chr;
	logic [2:0] pos_next;

	assign load_out = job_valid_q && (!out_valid_q || out_ready);
	assign job_done = load_out && (pos_q == POS_CHAR3);
	assign pop      = queue_not_empty && (!job_valid_q || job_done);

	assign k = 2'(pos_q - POS_CHAR0);

	always_comb begin
		case (k)
			2'd0:    six = job_q.group[23:18];
			2'd1:    six = job_q.group[17:12];
			2'd2:    six = job_q.group[11:6];
			default: six = job_q.group[5:0];
		endcase
		if (pos_q == POS_EOL_FIRST) begin
			chr = cfg.eol_first;
		end else if (pos_q == POS_EOL_SECOND) begin
			chr = cfg.eol_second;
		end else if (k <= job_q.nbytes) begin
			chr = b64_char(six);
		end else begin
			chr = PAD_CHAR;
		end
		if (pos_q == POS_EOL_FIRST && job_q.elen == 2'd1) begin
			pos_next = POS_CHAR0;
		end else begin
			pos_next = pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (load_out) begin
			out_char_q <= chr;
			run_last_q <= (pos_q == POS_CHAR3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			pos_q       <= POS_CHAR0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
				pos_q       <= (head_job.elen == 2'd0) ? POS_CHAR0 : POS_EOL_FIRST;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (load_out) begin
				pos_q <= pos_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (pos_q <= POS_CHAR3))
		else $error("emit position out of range");

	a_last_on_char3: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |=> (out_valid && run_last))
		else $error("group end not flagged on output");

	a_eol_only_when_asked: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_q && pos_q == POS_EOL_SECOND) |-> (job_q.elen == 2'd2))
		else $error("second line-break byte without request");

endmodule

>>> rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with configurable line breaks between groups.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    data_byte[7:0], final_byte
//   out      out_valid / out_ready  out_char[7:0], run_last
//   cfg      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// Output runs at one character per cycle while out_ready is high; a group of three
// bytes yields 4 characters plus 0..2 line-break bytes, as set by the byte packer.
// Input bytes are taken one per cycle while the job queue has room.
// A byte that closes a group passes the job queue and the emitter's job register first.
// Reset restores the default registers and clears all message state at once.
// Output stalls back up into the queue, then into in_ready; cfg_ready is always high.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
	parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       run_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import b64e_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.groups_per_line <= RST_GROUPS_PER_LINE;
			cfg_q.eol_length      <= RST_EOL_LENGTH;
			cfg_q.eol_first       <= RST_EOL_FIRST;
			cfg_q.eol_second      <= RST_EOL_SECOND;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GROUPS_PER_LINE: cfg_q.groups_per_line <= cfg_data[5:0];
				REG_EOL_LENGTH:      cfg_q.eol_length      <= cfg_data[1:0];
				REG_EOL_FIRST:       cfg_q.eol_first       <= cfg_data;
				REG_EOL_SECOND:      cfg_q.eol_second      <= cfg_data;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_fifo #(
		.DEPTH (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.head_job  (head_job),
		.not_empty (queue_not_empty)
	);

	b64e_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.queue_not_empty (queue_not_empty),
		.head_job        (head_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_char        (out_char),
		.run_last        (run_last)
	);

endmodule
